@@ src/pooled_priority_message_queue_macros.svh @@
// Assertion helpers for the queue RTL.
`ifndef POOLED_PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`define POOLED_PRIORITY_MESSAGE_QUEUE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PPMQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ppmq: invariant violated");

// A consequence that must hold in the cycle after its trigger.
`define PPMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppmq: sequence check failed");

`endif

@@ src/ppmq_pkg.sv @@
`default_nettype none

package ppmq_pkg;

    // A poll never emits more than this many messages.
    localparam logic [4:0] MAX_OUT = 5'd16;

    typedef enum logic {
        CMD_SEND = 1'b0,
        CMD_POLL = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_MESSAGE  = 2'd2,
        STAT_NONE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEND,
        S_POLL_RD,
        S_POLL_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;      // capture the accepted input item
        logic send_commit;  // store or drop the send, load its result
        logic poll_read;    // read the head slot of the top queue
        logic poll_commit;  // unlink that slot, load the message result
        logic poll_none;    // load the empty-poll result
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_is_poll;   // command of the item on the input channel
        logic poll_empty;   // nothing left to emit for this poll
        logic run_end;      // the message being emitted ends the poll
        logic out_free;     // the output register can take a result
    } t_dp_status;

endpackage

`default_nettype wire

@@ src/ppmq_in_if.sv @@
`default_nettype none

interface ppmq_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] dest;
    logic [1:0]  level;
    logic [63:0] body;
    logic [4:0]  max_count;

    modport source (output valid, command, dest, level, body, max_count, input ready);
    modport sink   (input valid, command, dest, level, body, max_count, output ready);
endinterface

`default_nettype wire

@@ src/ppmq_out_if.sv @@
`default_nettype none

interface ppmq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] ident;
    logic [31:0] out_dest;
    logic [1:0]  out_level;
    logic [63:0] out_body;
    logic [4:0]  held;
    logic        end_of_run;

    modport source (output valid, status, ident, out_dest, out_level, out_body, held,
                    end_of_run, input ready);
    modport sink   (input valid, status, ident, out_dest, out_level, out_body, held,
                    end_of_run, output ready);
endinterface

`default_nettype wire

@@ src/ppmq_ctrl.sv @@
`default_nettype none

module ppmq_ctrl
    import ppmq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_status.in_is_poll ? S_POLL_RD : S_SEND;
                end
            end
            S_SEND: begin
                if (i_status.out_free) begin
                    o_cmd.send_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POLL_RD: begin
                if (i_status.poll_empty) begin
                    if (i_status.out_free) begin
                        o_cmd.poll_none = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.poll_read = 1'b1;
                    n_state = S_POLL_OUT;
                end
            end
            S_POLL_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.poll_commit = 1'b1;
                    n_state = i_status.run_end ? S_IDLE : S_POLL_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/ppmq_dp.sv @@
`default_nettype none

`include "pooled_priority_message_queue_macros.svh"

module ppmq_dp
    import ppmq_pkg::*;
#(
    parameter int unsigned SLOTS  = 16,
    parameter int unsigned LEVELS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ppmq_in_if.sink     i_msg,
    ppmq_out_if.source  o_res,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status
);

    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned LVL_W  = $clog2(LEVELS);
    localparam int unsigned OCC_W  = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [31:0]      ident;
        logic [31:0]      dest;
        logic [LVL_W-1:0] level;
        logic [63:0]      body;
    } t_rec;

    // Captured input item.
    logic [31:0]      r_dest;
    logic [LVL_W-1:0] r_level;
    logic [63:0]      r_body;
    logic [4:0]       r_left;

    // Slot pool and queue bookkeeping.
    logic [SLOTS-1:0]  r_busy;
    logic [LEVELS-1:0] r_nonempty;
    logic [SLOT_W-1:0] r_head [LEVELS];
    logic [SLOT_W-1:0] r_tail [LEVELS];
    logic [OCC_W-1:0]  r_occ;
    logic [31:0]       r_last_ident;

    t_rec              mem_rec  [SLOTS];
    logic [SLOT_W-1:0] mem_link [SLOTS];
    t_rec              r_rd_rec;
    logic [SLOT_W-1:0] r_rd_link;

    // Slot being removed by the current poll step.
    logic [SLOT_W-1:0] r_slot;
    logic [LVL_W-1:0]  r_lvl_sel;
    logic              r_last_in_q;

    logic [SLOT_W-1:0] r_free_idx;
    logic              r_free_found;

    // Output register.
    logic        r_out_valid;
    t_status     r_status;
    logic [31:0] r_ident;
    logic [31:0] r_out_dest;
    logic [1:0]  r_out_level;
    logic [63:0] r_out_body;
    logic [4:0]  r_held;
    logic        r_end;

    logic [SLOT_W-1:0] free_idx;
    logic              free_found;
    logic [LVL_W-1:0]  top_lvl;
    logic [LEVELS-1:0] nonempty_after;
    logic [LVL_W-1:0]  in_level;
    logic [31:0]       next_ident;
    logic              out_free;
    logic              send_ok;

    // Lowest free slot, registered so a send reads it from a flop.
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // Highest non-empty level.
    always_comb begin
        top_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_nonempty[i]) begin
                top_lvl = LVL_W'(i);
            end
        end
    end

    always_comb begin
        nonempty_after = r_nonempty;
        if (r_last_in_q) begin
            nonempty_after[r_lvl_sel] = 1'b0;
        end
    end

    always_comb begin
        if (32'(i_msg.level) >= LEVELS) begin
            in_level = LVL_W'(LEVELS - 1);
        end else begin
            in_level = LVL_W'(i_msg.level);
        end
    end

    assign next_ident = r_last_ident + 32'd1;
    assign out_free   = !r_out_valid || o_res.ready;
    assign send_ok    = i_cmd.send_commit && r_free_found;

    assign o_status.in_is_poll = (t_command'(i_msg.command) == CMD_POLL);
    assign o_status.poll_empty = (r_left == 5'd0) || (r_nonempty == '0);
    assign o_status.run_end    = (r_left == 5'd1) || (nonempty_after == '0);
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        r_free_idx   <= free_idx;
        r_free_found <= free_found;
        if (i_cmd.load_in) begin
            r_dest  <= i_msg.dest;
            r_level <= in_level;
            r_body  <= i_msg.body;
            r_left  <= (i_msg.max_count > MAX_OUT) ? MAX_OUT : i_msg.max_count;
        end
        if (i_cmd.poll_read) begin
            r_slot      <= r_head[top_lvl];
            r_lvl_sel   <= top_lvl;
            r_last_in_q <= (r_head[top_lvl] == r_tail[top_lvl]);
        end
        if (i_cmd.poll_commit) begin
            r_left <= r_left - 5'd1;
        end
    end

    // Slot records and links.
    always_ff @(posedge i_clk) begin
        if (send_ok) begin
            mem_rec[r_free_idx] <= '{ident: next_ident, dest: r_dest, level: r_level,
                                     body: r_body};
            if (r_nonempty[r_level]) begin
                mem_link[r_tail[r_level]] <= r_free_idx;
            end
        end
        if (i_cmd.poll_read) begin
            r_rd_rec  <= mem_rec[r_head[top_lvl]];
            r_rd_link <= mem_link[r_head[top_lvl]];
        end
    end

    // Head and tail pointers are only read while their queue is non-empty.
    always_ff @(posedge i_clk) begin
        if (send_ok) begin
            r_tail[r_level] <= r_free_idx;
            if (!r_nonempty[r_level]) begin
                r_head[r_level] <= r_free_idx;
            end
        end
        if (i_cmd.poll_commit && !r_last_in_q) begin
            r_head[r_lvl_sel] <= r_rd_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= '0;
            r_nonempty   <= '0;
            r_occ        <= '0;
            r_last_ident <= '0;
        end else begin
            if (send_ok) begin
                r_busy[r_free_idx]  <= 1'b1;
                r_nonempty[r_level] <= 1'b1;
                r_occ               <= r_occ + OCC_W'(1);
                r_last_ident        <= next_ident;
            end
            if (i_cmd.poll_commit) begin
                r_busy[r_slot] <= 1'b0;
                r_nonempty     <= nonempty_after;
                r_occ          <= r_occ - OCC_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.send_commit || i_cmd.poll_commit || i_cmd.poll_none) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send_commit || i_cmd.poll_none) begin
            r_ident     <= '0;
            r_out_dest  <= '0;
            r_out_level <= '0;
            r_out_body  <= '0;
            r_held      <= 5'(r_occ);
            r_end       <= 1'b1;
            if (i_cmd.poll_none) begin
                r_status <= STAT_NONE;
            end else if (r_free_found) begin
                r_status <= STAT_ACCEPTED;
                r_ident  <= next_ident;
                r_held   <= 5'(r_occ + OCC_W'(1));
            end else begin
                r_status <= STAT_FULL;
            end
        end else if (i_cmd.poll_commit) begin
            r_status    <= STAT_MESSAGE;
            r_ident     <= r_rd_rec.ident;
            r_out_dest  <= r_rd_rec.dest;
            r_out_level <= 2'(r_rd_rec.level);
            r_out_body  <= r_rd_rec.body;
            r_held      <= 5'(r_occ - OCC_W'(1));
            r_end       <= o_status.run_end;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.ident      = r_ident;
    assign o_res.out_dest   = r_out_dest;
    assign o_res.out_level  = r_out_level;
    assign o_res.out_body   = r_out_body;
    assign o_res.held       = r_held;
    assign o_res.end_of_run = r_end;

    `PPMQ_ASSERT_ALWAYS(a_occ_matches_busy, i_clk, i_rst_n, $countones(r_busy) == r_occ)
    `PPMQ_ASSERT_ALWAYS(a_empty_queues_empty_pool, i_clk, i_rst_n, (r_nonempty != '0) || (r_occ == '0))
    `PPMQ_ASSERT_NEXT(a_send_takes_slot, i_clk, i_rst_n, send_ok, r_occ == $past(r_occ) + OCC_W'(1))

endmodule

`default_nettype wire

@@ src/pooled_priority_message_queue.sv @@
// Pooled strict-priority message queue.
//
// Items arrive on i_msg (valid/ready). A send (command 0) stores its message in
// the lowest free slot of a pool of SLOTS entries and queues it on its priority
// level; a poll (command 1) drains up to max_count messages, highest level first
// and oldest first within a level. Results leave on o_res (valid/ready), one per
// send and one per emitted message, with end_of_run set on the last result of
// each item. A send on a full pool and a poll that finds nothing each give one
// result of their own.
// Steps: a send is accepted, then committed into the output register. A poll
// is accepted and then, for each emitted message, reads its slot memory entry
// into a register (S_POLL_RD) and commits it to the output register (S_POLL_OUT);
// a poll that emits nothing is accepted and then commits only its none result.
// One item is worked on at a time; i_msg.ready is high only while idle.
// The output register decouples the two sides: when o_res stalls, the block
// holds its current step until the register frees up, and nothing is dropped.
// Reset (synchronous, active low) empties the pool and all queues at once and
// restarts message ids so that the first accepted send gets id 1.
`default_nettype none

module pooled_priority_message_queue
    import ppmq_pkg::*;
#(
    parameter int unsigned SLOTS  = 16,
    parameter int unsigned LEVELS = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ppmq_in_if.sink    i_msg,
    ppmq_out_if.source o_res
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // The controller sequences sends and polls; the datapath owns all storage.
    ppmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_msg.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // The input channel is open exactly while the controller is idle.
    assign i_msg.ready = in_ready;

    ppmq_dp #(
        .SLOTS  (SLOTS),
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (i_msg),
        .o_res    (o_res),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;
    import ppmq_pkg::*;

    localparam int unsigned SLOTS  = 16;
    localparam int unsigned LEVELS = 4;

    // One input item as the driver presents it on the message channel.
    typedef struct packed {
        t_command    command;
        logic [31:0] dest;
        logic [1:0]  level;
        logic [63:0] body;
        logic [4:0]  max_count;
    } t_msg_item;

    // One result item as the block should emit it.
    typedef struct packed {
        t_status     status;
        logic [31:0] ident;
        logic [31:0] out_dest;
        logic [1:0]  out_level;
        logic [63:0] out_body;
        logic [4:0]  held;
        logic        end_of_run;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ppmq_in_if  msg_if ();
    ppmq_out_if res_if ();

    pooled_priority_message_queue #(
        .SLOTS  (SLOTS),
        .LEVELS (LEVELS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Items waiting to be offered, and results the block still owes us.
    t_msg_item outbox[$];
    t_result   due_results[$];

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    int fail_count   = 0;
    int items_taken  = 0;
    int seen_stored  = 0;
    int seen_dropped = 0;
    int seen_message = 0;
    int seen_none    = 0;

    // Shadow of the block's pool and priority queues. The links, heads and
    // tails are only looked at while the owning queue is non-empty, just as
    // in the block itself.
    bit          pool_busy[SLOTS];
    logic [3:0]  pool_link[SLOTS];
    logic [31:0] pool_ident[SLOTS];
    logic [31:0] pool_dest[SLOTS];
    logic [1:0]  pool_level[SLOTS];
    logic [63:0] pool_body[SLOTS];
    logic [3:0]  lvl_head[LEVELS];
    logic [3:0]  lvl_tail[LEVELS];
    bit          lvl_nonempty[LEVELS];
    logic [4:0]  pool_count = '0;
    logic [31:0] id_counter = '0;

    function automatic t_result make_result(t_status st, logic [31:0] id, logic [31:0] dst,
                                            logic [1:0] lvl, logic [63:0] body, logic last);
        t_result r;
        r.status     = st;
        r.ident      = id;
        r.out_dest   = dst;
        r.out_level  = lvl;
        r.out_body   = body;
        r.held       = pool_count;
        r.end_of_run = last;
        return r;
    endfunction

    // Advances the shadow state by one accepted item and appends every result
    // that the item causes, in the order the block must emit them.
    function automatic void forecast_results(t_msg_item it);
        int         free_slot;
        int         top;
        int         limit;
        int         n;
        logic [1:0] lvl;
        logic [3:0] s;
        t_result    held_back;
        if (it.command == CMD_SEND) begin
            // A two-bit level never exceeds LEVELS-1 with four levels, so the
            // saturation of out-of-range levels cannot trigger here.
            lvl = (it.level >= LEVELS) ? 2'(LEVELS - 1) : it.level;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!pool_busy[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
                // Pool full: the message is dropped and no id is consumed.
                due_results.push_back(make_result(STAT_FULL, '0, '0, '0, '0, 1'b1));
            end else begin
                id_counter = id_counter + 32'd1;
                pool_busy[free_slot]  = 1'b1;
                pool_ident[free_slot] = id_counter;
                pool_dest[free_slot]  = it.dest;
                pool_level[free_slot] = lvl;
                pool_body[free_slot]  = it.body;
                pool_link[free_slot]  = '0;
                if (lvl_nonempty[lvl]) begin
                    pool_link[lvl_tail[lvl]] = 4'(free_slot);
                end else begin
                    lvl_head[lvl]     = 4'(free_slot);
                    lvl_nonempty[lvl] = 1'b1;
                end
                lvl_tail[lvl] = 4'(free_slot);
                pool_count = pool_count + 5'd1;
                due_results.push_back(make_result(STAT_ACCEPTED, id_counter, '0, '0, '0, 1'b1));
            end
        end else begin
            limit = (it.max_count > MAX_OUT) ? int'(MAX_OUT) : int'(it.max_count);
            n = 0;
            while (n < limit) begin
                top = -1;
                for (int p = LEVELS - 1; p >= 0; p--) begin
                    if (lvl_nonempty[p] && top < 0) top = p;
                end
                if (top < 0) break;
                s = lvl_head[top];
                if (s == lvl_tail[top]) lvl_nonempty[top] = 1'b0;
                else lvl_head[top] = pool_link[s];
                pool_busy[s] = 1'b0;
                if (pool_count > 0) pool_count = pool_count - 5'd1;
                // The previous message is pushed only once we know it is not
                // the last one of this poll.
                if (n > 0) due_results.push_back(held_back);
                held_back = make_result(STAT_MESSAGE, pool_ident[s], pool_dest[s],
                                        pool_level[s], pool_body[s], 1'b0);
                n++;
            end
            if (n == 0) begin
                // Nothing queued, or a count of zero: a single none result.
                due_results.push_back(make_result(STAT_NONE, '0, '0, '0, '0, 1'b1));
            end else begin
                held_back.end_of_run = 1'b1;
                due_results.push_back(held_back);
            end
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void queue_send(logic [31:0] dst, logic [1:0] lvl, logic [63:0] body);
        t_msg_item it;
        it.command   = CMD_SEND;
        it.dest      = dst;
        it.level     = lvl;
        it.body      = body;
        // A send does not look at the count, so it carries noise there.
        it.max_count = 5'($urandom_range(0, 31));
        outbox.push_back(it);
    endfunction

    function automatic void queue_poll(logic [4:0] count);
        t_msg_item it;
        it.command   = CMD_POLL;
        it.dest      = $urandom();
        it.level     = 2'($urandom_range(0, 3));
        it.body      = {$urandom(), $urandom()};
        it.max_count = count;
        outbox.push_back(it);
    endfunction

    // One random item. send_bias is the percent chance of a send; it moves
    // between blocks of items so that the pool both fills up and drains.
    function automatic void queue_random_item(int send_bias);
        int roll;
        if ($urandom_range(0, 99) < send_bias) begin
            queue_send($urandom(), 2'($urandom_range(0, 3)), {$urandom(), $urandom()});
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) queue_poll(5'($urandom_range(1, 4)));
            else if (roll < 85) queue_poll(5'($urandom_range(0, 15)));
            else queue_poll(5'($urandom_range(16, 31)));
        end
    endfunction

    // Driver: offers the oldest pending item and holds it until the block
    // takes it. The expected results are worked out at the accepting edge.
    always @(posedge i_clk) begin : msg_driver
        t_msg_item taken;
        if (!i_rst_n) begin
            msg_if.valid <= 1'b0;
        end else begin
            if (msg_if.valid && msg_if.ready) begin
                taken = outbox.pop_front();
                forecast_results(taken);
                items_taken++;
            end
            if (!(msg_if.valid && !msg_if.ready)) begin
                if (outbox.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    msg_if.valid     <= 1'b1;
                    msg_if.command   <= outbox[0].command;
                    msg_if.dest      <= outbox[0].dest;
                    msg_if.level     <= outbox[0].level;
                    msg_if.body      <= outbox[0].body;
                    msg_if.max_count <= outbox[0].max_count;
                end else begin
                    msg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result is held against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result with status %0d, nothing outstanding",
                           res_if.status);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 64'(want.status), 64'(res_if.status));
                    check_field("ident", 64'(want.ident), 64'(res_if.ident));
                    check_field("out_dest", 64'(want.out_dest), 64'(res_if.out_dest));
                    check_field("out_level", 64'(want.out_level), 64'(res_if.out_level));
                    check_field("out_body", want.out_body, res_if.out_body);
                    check_field("held", 64'(want.held), 64'(res_if.held));
                    check_field("end_of_run", 64'(want.end_of_run),
                                64'(res_if.end_of_run));
                    unique case (want.status)
                        STAT_ACCEPTED: seen_stored++;
                        STAT_FULL:     seen_dropped++;
                        STAT_MESSAGE:  seen_message++;
                        default:       seen_none++;
                    endcase
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Each phase pairs a sender idling rate with a receiver stalling rate.
    int phase_idle[4]  = '{0, 71, 0, 17};
    int phase_stall[4] = '{0, 0, 71, 17};

    initial begin
        int send_bias;
        msg_if.valid     = 1'b0;
        msg_if.command   = CMD_SEND;
        msg_if.dest      = '0;
        msg_if.level     = '0;
        msg_if.body      = '0;
        msg_if.max_count = '0;
        res_if.ready     = 1'b0;
        send_bias        = 60;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Polls on an empty pool come first, then the field
        // extremes, a zero-count poll with messages held, an oversized count,
        // and finally a pool filled to the brim with one send too many.
        queue_poll(5'd0);
        queue_poll(5'd5);
        queue_send('0, 2'd0, '0);
        queue_send('1, 2'd3, '1);
        queue_send(32'h5555_AAAA, 2'd1, 64'hAAAA_5555_AAAA_5555);
        queue_send(32'hAAAA_5555, 2'd2, 64'h5555_AAAA_5555_AAAA);
        queue_poll(5'd0);
        queue_poll(5'd31);
        for (int i = 0; i < SLOTS + 1; i++) begin
            queue_send($urandom(), 2'(i % 4), {$urandom(), $urandom()});
        end
        // Exactly the maximum count drains the whole pool in one poll.
        queue_poll(5'd16);

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (int k = 0; k < 96; k++) begin
                if (k % 32 == 0) send_bias = $urandom_range(35, 85);
                queue_random_item(send_bias);
            end
            while (outbox.size() != 0 || due_results.size() != 0) @(posedge i_clk);
        end

        // A poll emits its messages one after another, so a short tail is enough
        // to catch any stray result after the last expected one.
        repeat (40) @(posedge i_clk);

        $display("Ran %0d items through four idling phases: %0d sends stored, %0d dropped",
                 items_taken, seen_stored, seen_dropped);
        $display("on a full pool, %0d messages polled out and %0d empty polls; %0d errors.",
                 seen_message, seen_none, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/ppmq_pkg.sv
src/ppmq_in_if.sv
src/ppmq_out_if.sv
src/ppmq_ctrl.sv
src/ppmq_dp.sv
src/pooled_priority_message_queue.sv
bench/tb_top.sv
